### rtl/odo_pkg.sv
// Shared types, codes and constants for the odometer trapezoid accumulator.
package odo_pkg;

    localparam int SPEED_W   = 10;
    localparam int SCALE_W   = 10;
    localparam int SCALED_W  = 20;
    localparam int UNIT_W    = 20;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(278);
    localparam logic [UNIT_W-1:0]  UNIT_RESET  = UNIT_W'(10000);
    localparam logic [UNIT_W-1:0]  DIST_DIVISOR = UNIT_W'(1000);

    // x / 1000 == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
    localparam int DIST_SHIFT = 38;
    localparam int RECIP_W    = 29;
    localparam logic [RECIP_W-1:0] DIST_RECIP =
        RECIP_W'(((64'd1 << DIST_SHIFT) + 64'(DIST_DIVISOR) - 64'd1) / 64'(DIST_DIVISOR));

    // operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SIZE   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_MUL,
        ST_SUM,
        ST_DIV_DIST,
        ST_ADD,
        ST_CHECK,
        ST_DIV_ROLL,
        ST_ROLL,
        ST_FINISH,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic idle;
        logic scale;
        logic mul;
        logic sum;
        logic div_dist;
        logic add;
        logic div_roll;
        logic roll;
        logic finish;
        logic load_out;
    } odo_cmd_t;

    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            have_ref;
        logic            div_done;
        logic            need_roll;
        logic            out_busy;
    } odo_status_t;

endpackage

### rtl/odo_if.sv
// Valid/ready channel interfaces for input words and result words.
interface odo_in_if;
    import odo_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [SPEED_W-1:0]  speed;
    logic [WORD_W-1:0]   time_ms;
    logic [WORD_W-1:0]   load_full;
    logic [WORD_W-1:0]   load_partial;

    modport source (output valid, operation, speed, time_ms, load_full, load_partial,
                    input ready);
    modport sink   (input valid, operation, speed, time_ms, load_full, load_partial,
                    output ready);
endinterface

interface odo_out_if;
    import odo_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] full_count;
    logic [WORD_W-1:0] partial_count;
    logic              rolled_over;

    modport source (output valid, full_count, partial_count, rolled_over, input ready);
    modport sink   (input valid, full_count, partial_count, rolled_over, output ready);
endinterface

### rtl/odo_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module odo_div
    import odo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [UNIT_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient,
    output logic [UNIT_W-1:0] remainder
);

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [UNIT_W-1:0] rem_reg;
    logic [UNIT_W-1:0] dvs_reg;

    logic [UNIT_W:0]   trial;
    logic              fits;
    logic [UNIT_W:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[WORD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WORD_W-2:0], fits};
            rem_reg <= fits ? diff[UNIT_W-1:0] : trial[UNIT_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/odo_dp.sv
// Datapath: configuration, reference and counter registers, multipliers, divider, output register.
module odo_dp
    import odo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  odo_cmd_t              cmd,
    output odo_status_t           status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    odo_in_if.sink                in_ch,
    odo_out_if.source             out_ch
);

    logic [SCALE_W-1:0]  scale_reg;
    logic [UNIT_W-1:0]   unit_reg;

    logic [OP_W-1:0]     op_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [WORD_W-1:0]   time_reg;
    logic [WORD_W-1:0]   ld_full_reg;
    logic [WORD_W-1:0]   ld_part_reg;

    logic                have_ref_reg;
    logic [SCALED_W-1:0] ref_speed_reg;
    logic [WORD_W-1:0]   ref_time_reg;
    logic [WORD_W-1:0]   partial_reg;
    logic [WORD_W-1:0]   full_reg;
    logic                rolled_reg;

    logic [SCALED_W-1:0] scaled_reg;
    logic [WORD_W-1:0]   dt_reg;
    logic [WORD_W-1:0]   prod_lo_reg;
    logic [WORD_W-1:0]   prod_diff_reg;
    logic [WORD_W-1:0]   sum_reg;
    logic [WORD_W-1:0]   dist_reg;

    logic                out_valid_reg;
    logic [WORD_W-1:0]   out_full_reg;
    logic [WORD_W-1:0]   out_part_reg;
    logic                out_rolled_reg;

    logic                capture;
    logic [SCALED_W-1:0] spd_lo;
    logic [SCALED_W-1:0] spd_hi;
    logic [WORD_W+RECIP_W-1:0] recip_prod;
    logic                div_start;
    logic [WORD_W-1:0]   div_dividend;
    logic [UNIT_W-1:0]   div_divisor;
    logic                div_done;
    logic [WORD_W-1:0]   div_quo;
    logic [UNIT_W-1:0]   div_rem;

    assign in_ch.ready = cmd.idle;
    assign capture     = cmd.idle & in_ch.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            unit_reg  <= UNIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPEED_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_UNIT_SIZE:   unit_reg  <= cfg_data[UNIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            op_reg      <= in_ch.operation;
            speed_reg   <= in_ch.speed;
            time_reg    <= in_ch.time_ms;
            ld_full_reg <= in_ch.load_full;
            ld_part_reg <= in_ch.load_partial;
        end
    end

    // trapezoid terms
    always_comb
    begin
        if (scaled_reg < ref_speed_reg)
        begin
            spd_lo = scaled_reg;
            spd_hi = ref_speed_reg;
        end
        else
        begin
            spd_lo = ref_speed_reg;
            spd_hi = scaled_reg;
        end
    end

    // divide by 1000 through the reciprocal
    assign recip_prod = (WORD_W+RECIP_W)'(sum_reg) * (WORD_W+RECIP_W)'(DIST_RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            scaled_reg <= SCALED_W'(speed_reg) * SCALED_W'(scale_reg);
            dt_reg     <= time_reg - ref_time_reg;
        end
        if (cmd.mul)
        begin
            prod_lo_reg   <= WORD_W'(spd_lo) * dt_reg;
            prod_diff_reg <= WORD_W'(spd_hi - spd_lo) * dt_reg;
        end
        if (cmd.sum)
        begin
            sum_reg <= prod_lo_reg + (prod_diff_reg >> 1);
        end
        if (cmd.div_dist)
        begin
            dist_reg <= WORD_W'(recip_prod[WORD_W+RECIP_W-1:DIST_SHIFT]);
        end
    end

    assign div_start    = cmd.div_roll;
    assign div_dividend = partial_reg - WORD_W'(1);
    assign div_divisor  = unit_reg;

    odo_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_ref_reg  <= 1'b0;
            ref_speed_reg <= '0;
            ref_time_reg  <= '0;
            partial_reg   <= '0;
            full_reg      <= '0;
            rolled_reg    <= 1'b0;
        end
        else
        begin
            if (capture)
            begin
                rolled_reg <= 1'b0;
            end
            if (cmd.add)
            begin
                partial_reg <= partial_reg + dist_reg;
            end
            if (cmd.roll)
            begin
                // partial - n*unit equals ((partial-1) mod unit) + 1
                partial_reg <= WORD_W'(div_rem) + WORD_W'(1);
                full_reg    <= full_reg + div_quo;
                rolled_reg  <= 1'b1;
            end
            if (cmd.finish)
            begin
                case (op_reg)
                    OP_SAMPLE:
                    begin
                        have_ref_reg  <= 1'b1;
                        ref_speed_reg <= scaled_reg;
                        ref_time_reg  <= time_reg;
                    end
                    OP_RESTART:
                    begin
                        have_ref_reg <= 1'b0;
                    end
                    OP_LOAD:
                    begin
                        full_reg    <= ld_full_reg;
                        partial_reg <= ld_part_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_full_reg   <= full_reg;
            out_part_reg   <= partial_reg;
            out_rolled_reg <= rolled_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.full_count    = out_full_reg;
    assign out_ch.partial_count = out_part_reg;
    assign out_ch.rolled_over   = out_rolled_reg;

    always_comb
    begin
        status.in_valid  = in_ch.valid;
        status.op        = op_reg;
        status.have_ref  = have_ref_reg;
        status.div_done  = div_done;
        status.need_roll = (unit_reg != '0) && (partial_reg > WORD_W'(unit_reg));
        status.out_busy  = out_valid_reg & ~out_ch.ready;
    end

endmodule

### rtl/odo_ctrl.sv
// Controller state machine that sequences the odometer datapath.
module odo_ctrl
    import odo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  odo_status_t status,
    output odo_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if ((status.op == OP_SAMPLE) && status.have_ref)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:      state_next = ST_SUM;
            ST_SUM:      state_next = ST_DIV_DIST;
            ST_DIV_DIST: state_next = ST_ADD;
            ST_ADD:      state_next = ST_CHECK;
            ST_CHECK:
            begin
                state_next = status.need_roll ? ST_DIV_ROLL : ST_FINISH;
            end
            ST_DIV_ROLL:
            begin
                if (status.div_done)
                begin
                    state_next = ST_ROLL;
                end
            end
            ST_ROLL:     state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.idle     = (state_reg == ST_IDLE);
        cmd.scale    = (state_reg == ST_SCALE);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.div_dist = (state_reg == ST_DIV_DIST);
        cmd.add      = (state_reg == ST_ADD);
        cmd.div_roll = (state_reg == ST_CHECK) && status.need_roll;
        cmd.roll     = (state_reg == ST_ROLL);
        cmd.finish   = (state_reg == ST_FINISH);
        cmd.load_out = (state_reg == ST_OUT) && !status.out_busy;
    end

endmodule

### rtl/odometer_trapezoid_accumulator.sv
// Sequence: restart, load, unused code or first sample go from SCALE to FINISH and OUT, where
// the result word is registered. Sample with reference: SCALE, MUL, SUM, DIV_DIST, ADD, CHECK,
// FINISH, OUT; on a rollover CHECK starts the one-bit-per-cycle divider on (partial-1)/unit_size
// and DIV_ROLL waits for it before ROLL. Throughput: one word at a time; OUT waits while the
// last result is stalled, and a new word is taken the cycle after the result is registered.
// Reset: rst_n async active low; counters and reference cleared, scale 278, unit 10000.
module odometer_trapezoid_accumulator
    import odo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    odo_in_if.sink                in_ch,
    odo_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Controller drives per-state commands; datapath reports operation,
    // reference flag, divider completion, rollover need and output backpressure.
    odo_cmd_t    cmd;
    odo_status_t status;

    odo_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Distance is (lo*dt + ((hi-lo)*dt)/2) / 1000, all modulo 2^32; the divide
    // by 1000 is a reciprocal multiply. The serial divider then splits
    // (partial-1) by unit_size into the full-count step and the new partial count.
    odo_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule
